// ===== src/best_fit_hole_allocator_core_macros.svh =====
// assertion macros for the best fit hole allocator
// bodies expect clk and arst_n in the using module
`ifndef BEST_FIT_HOLE_ALLOCATOR_CORE_MACROS_SVH
`define BEST_FIT_HOLE_ALLOCATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define BFHA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bfha assertion failed");
`define BFHA_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("bfha forbidden condition");
`else
`define BFHA_ASSERT(lbl, prop)
`define BFHA_NEVER(lbl, expr)
`endif
`endif

// ===== src/bfha_pkg.sv =====
// shared types and codes of the best fit hole allocator
// no dependencies
package bfha_pkg;

	localparam int SZ_W  = 32;
	localparam int PS_W  = 33;
	localparam int PAD_W = 17;
	localparam int AP_W  = 48;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_MARK  = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;

	localparam logic [PAD_W-1:0] PAD_RESET = 17'd4096;

	typedef struct packed {
		logic [1:0]      cmd;
		logic [47:0]     req_position;
		logic [SZ_W-1:0] req_size;
	} req_t;

	typedef struct packed {
		logic [AP_W-1:0] alloc_position;
		logic [1:0]      status;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_PREP,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_WRA,
		ST_FIN
	} fsm_t;

endpackage

// ===== src/best_fit_hole_allocator_core.sv =====
// best fit hole allocator: top level, sequencer, scan and update
// uses bfha_pkg, bfha_pad, bfha_ram and the assertion macro header
//
// usage
// in channel: one command word (allocate, free, mark) with position and size.
// out channel: one result word per command, start position and status.
// cfg channel: writes the pad unit, always ready; the user must write it only
// while idle, which the block does not enforce.
// each command runs on a shared sequencer: the size is first rounded
// (a start step, then one remainder bit per cycle), then one pass over all
// MAX_HOLES table entries through the single ram read port, then up to two
// ram writes.
// size zero skips rounding and scan and goes straight to the result state.
// in_ready is high only between commands.
// reset clears the end pointer and every hole valid bit, and sets the pad
// unit to 4096; the hole ram itself is not cleared.
// a stalled receiver holds the result in the output register; the next
// command is taken meanwhile and waits at its end for the register to free.
`include "best_fit_hole_allocator_core_macros.svh"
module best_fit_hole_allocator_core #(
	parameter int MAX_HOLES = 64,
	parameter int POS_BITS  = 48
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  bfha_pkg::req_t             in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output bfha_pkg::rsp_t             out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bfha_pkg::PAD_W-1:0] cfg_data
);
	import bfha_pkg::*;

	localparam int AW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
	localparam int P  = POS_BITS;
	localparam int EW = ((P > PS_W) ? P : PS_W) + 2;
	localparam logic [EW-1:0] MASK_EW = {{(EW-P){1'b0}}, {P{1'b1}}};

	fsm_t state_q, state_d;

	logic [PAD_W-1:0]   pad_q;
	logic [P-1:0]       end_q;
	logic [MAX_HOLES-1:0] valid_q;

	logic [1:0]         cmd_q;
	logic [P-1:0]       pos_q;
	logic [SZ_W-1:0]    sz_q;
	logic [PS_W-1:0]    ps_q;
	logic [EW-1:0]      re_ew_q;
	logic [P-1:0]       re_q;
	logic               fit_re_q;
	logic               fit_end_q;
	logic [P-1:0]       end_sum_q;

	logic               pad_start, pad_done;
	logic [PS_W-1:0]    pad_ps;

	logic [AW:0]        scan_q;
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic [2*P-1:0]     rdata;
	logic [P-1:0]       rd_start, rd_len;

	logic               bf_found_q, at_found_q, rf_found_q, bef_found_q, inr_q, slot_found_q;
	logic [AW-1:0]      bf_idx_q, at_idx_q, rf_idx_q, bef_idx_q, slot_idx_q;
	logic [P-1:0]       bf_start_q, bf_len_q, at_len_q, rf_len_q, bef_start_q, bef_len_q;

	logic [1:0]         stat_q;
	logic [P-1:0]       res_q;
	logic               wa_en_q, wb_en_q;
	logic [AW-1:0]      wa_idx_q, wb_idx_q;
	logic [P-1:0]       wa_s_q, wa_l_q, wb_s_q, wb_l_q;

	logic               out_valid_q;
	rsp_t               out_q;

	logic [1:0]         d_stat;
	logic [P-1:0]       d_res;
	logic               d_end_en;
	logic [P-1:0]       d_end;
	logic               wa_en, wb_en, clr_en;
	logic [AW-1:0]      wa_idx, wb_idx, clr_idx;
	logic [P-1:0]       wa_s, wa_l, wb_s, wb_l;
	logic [EW-1:0]      ps_ew, bef_end_ew, pos_ew, end_ew;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [2*P-1:0]     ram_wdata;
	logic               in_fire, out_free;

	assign in_fire   = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	bfha_pad u_pad (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pad_start),
		.sz     (sz_q),
		.unit   (pad_q),
		.done   (pad_done),
		.ps     (pad_ps)
	);

	bfha_ram #(.WIDTH(2*P), .DEPTH(MAX_HOLES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (scan_q[AW-1:0]),
		.rdata (rdata)
	);

	assign rd_start = rdata[2*P-1:P];
	assign rd_len   = rdata[P-1:0];

	assign ram_we    = (state_q == ST_WRA && wa_en_q) || (state_q == ST_FIN && wb_en_q);
	assign ram_waddr = (state_q == ST_WRA) ? wa_idx_q : wb_idx_q;
	assign ram_wdata = (state_q == ST_WRA) ? {wa_s_q, wa_l_q} : {wb_s_q, wb_l_q};

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_data.req_size == '0) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (pad_done) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_q[AW-1:0] == AW'(MAX_HOLES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_WRA;
			ST_WRA:    state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// pad start in the cycle after accept, once sz_q holds the size
	logic pad_go_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_go_q <= 1'b0;
		end else begin
			pad_go_q <= in_fire && (in_data.req_size != '0);
		end
	end

	assign pad_start = pad_go_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q       <= PAD_RESET;
			end_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
			scan_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pad_q <= cfg_data;
			end
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_SCAN) begin
				scan_q <= scan_q + (AW+1)'(1);
			end else begin
				scan_q <= '0;
			end
			if (state_q == ST_DECIDE) begin
				if (d_end_en) begin
					end_q <= d_end;
				end
				if (clr_en) begin
					valid_q[clr_idx] <= 1'b0;
				end
				if (wa_en) begin
					valid_q[wa_idx] <= 1'b1;
				end
				if (wb_en) begin
					valid_q[wb_idx] <= 1'b1;
				end
			end
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pos_ew = EW'(pos_q);
	assign end_ew = EW'(end_q);
	assign ps_ew  = EW'(ps_q);

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q[AW-1:0];
		if (in_fire) begin
			cmd_q  <= in_data.cmd;
			pos_q  <= P'(in_data.req_position);
			sz_q   <= in_data.req_size;
			stat_q <= STAT_OK;
			res_q  <= '0;
		end
		if (pad_done) begin
			ps_q <= pad_ps;
		end
		if (state_q == ST_PREP) begin
			re_ew_q      <= pos_ew + ps_ew;
			re_q         <= P'(pos_ew + ps_ew);
			fit_re_q     <= (pos_ew + ps_ew) <= MASK_EW;
			fit_end_q    <= (end_ew + ps_ew) <= MASK_EW;
			end_sum_q    <= P'(end_ew + ps_ew);
			bf_found_q   <= 1'b0;
			at_found_q   <= 1'b0;
			rf_found_q   <= 1'b0;
			bef_found_q  <= 1'b0;
			inr_q        <= 1'b0;
			slot_found_q <= 1'b0;
		end
		if (rd_vld_s1) begin
			if (!valid_q[rd_idx_s1]) begin
				if (!slot_found_q) begin
					slot_found_q <= 1'b1;
					slot_idx_q   <= rd_idx_s1;
				end
			end else begin
				if (EW'(rd_len) >= ps_ew && (!bf_found_q || rd_len < bf_len_q ||
						(rd_len == bf_len_q && rd_start < bf_start_q))) begin
					bf_found_q <= 1'b1;
					bf_idx_q   <= rd_idx_s1;
					bf_start_q <= rd_start;
					bf_len_q   <= rd_len;
				end
				if (rd_start == pos_q && !at_found_q) begin
					at_found_q <= 1'b1;
					at_idx_q   <= rd_idx_s1;
					at_len_q   <= rd_len;
				end
				if (rd_start == re_q && !rf_found_q) begin
					rf_found_q <= 1'b1;
					rf_idx_q   <= rd_idx_s1;
					rf_len_q   <= rd_len;
				end
				if (rd_start < pos_q && (!bef_found_q || rd_start > bef_start_q)) begin
					bef_found_q <= 1'b1;
					bef_idx_q   <= rd_idx_s1;
					bef_start_q <= rd_start;
					bef_len_q   <= rd_len;
				end
				if (rd_start >= pos_q && EW'(rd_start) < re_ew_q) begin
					inr_q <= 1'b1;
				end
			end
		end
		if (state_q == ST_DECIDE) begin
			stat_q   <= d_stat;
			res_q    <= d_res;
			wa_en_q  <= wa_en;
			wb_en_q  <= wb_en;
			wa_idx_q <= wa_idx;
			wb_idx_q <= wb_idx;
			wa_s_q   <= wa_s;
			wa_l_q   <= wa_l;
			wb_s_q   <= wb_s;
			wb_l_q   <= wb_l;
		end
		if (state_q == ST_IDLE) begin
			wa_en_q <= 1'b0;
			wb_en_q <= 1'b0;
		end
		if (state_q == ST_FIN && out_free) begin
			out_q.alloc_position <= AP_W'(res_q);
			out_q.status         <= stat_q;
		end
	end

	assign bef_end_ew = EW'(bef_start_q) + EW'(bef_len_q);

	// decision for the command once the scan is complete
	always_comb begin
		d_stat   = STAT_OK;
		d_res    = '0;
		d_end_en = 1'b0;
		d_end    = end_q;
		wa_en    = 1'b0;
		wb_en    = 1'b0;
		clr_en   = 1'b0;
		wa_idx   = slot_idx_q;
		wb_idx   = slot_idx_q;
		clr_idx  = bf_idx_q;
		wa_s     = '0;
		wa_l     = '0;
		wb_s     = '0;
		wb_l     = '0;
		unique case (cmd_q)
			CMD_ALLOC: begin
				if (bf_found_q) begin
					d_res = bf_start_q;
					if (EW'(bf_len_q) == ps_ew) begin
						clr_en  = 1'b1;
						clr_idx = bf_idx_q;
					end else begin
						wa_en  = 1'b1;
						wa_idx = bf_idx_q;
						wa_s   = bf_start_q + P'(ps_q);
						wa_l   = bf_len_q - P'(ps_q);
					end
				end else if (!fit_end_q) begin
					d_stat = STAT_BAD;
				end else begin
					d_res    = end_q;
					d_end_en = 1'b1;
					d_end    = end_sum_q;
				end
			end
			CMD_MARK: begin
				if (!fit_re_q) begin
					d_stat = STAT_BAD;
				end else if (pos_q == end_q) begin
					d_end_en = 1'b1;
					d_end    = re_q;
				end else if (pos_q > end_q) begin
					if (!slot_found_q) begin
						d_stat = STAT_FULL;
					end else begin
						wa_en    = 1'b1;
						wa_idx   = slot_idx_q;
						wa_s     = end_q;
						wa_l     = pos_q - end_q;
						d_end_en = 1'b1;
						d_end    = re_q;
					end
				end else if (at_found_q) begin
					if (EW'(at_len_q) < ps_ew) begin
						d_stat = STAT_BAD;
					end else if (EW'(at_len_q) == ps_ew) begin
						clr_en  = 1'b1;
						clr_idx = at_idx_q;
					end else begin
						wa_en  = 1'b1;
						wa_idx = at_idx_q;
						wa_s   = re_q;
						wa_l   = at_len_q - P'(ps_q);
					end
				end else if (!bef_found_q || bef_end_ew < re_ew_q) begin
					d_stat = STAT_BAD;
				end else begin
					wa_en  = 1'b1;
					wa_idx = bef_idx_q;
					wa_s   = bef_start_q;
					wa_l   = pos_q - bef_start_q;
					if (re_ew_q < bef_end_ew) begin
						if (!slot_found_q) begin
							d_stat = STAT_FULL;
						end else begin
							wb_en  = 1'b1;
							wb_idx = slot_idx_q;
							wb_s   = re_q;
							wb_l   = P'(bef_end_ew - re_ew_q);
						end
					end
				end
			end
			CMD_FREE: begin
				if (!fit_re_q || pos_q >= end_q || re_q > end_q || inr_q ||
						(bef_found_q && bef_end_ew > pos_ew)) begin
					d_stat = STAT_BAD;
				end else if (!rf_found_q && end_q == re_q) begin
					d_end_en = 1'b1;
					if (bef_found_q && bef_end_ew == pos_ew) begin
						d_end   = bef_start_q;
						clr_en  = 1'b1;
						clr_idx = bef_idx_q;
					end else begin
						d_end = pos_q;
					end
				end else if (rf_found_q && bef_found_q && bef_end_ew == pos_ew) begin
					wa_en   = 1'b1;
					wa_idx  = bef_idx_q;
					wa_s    = bef_start_q;
					wa_l    = bef_len_q + P'(ps_q) + rf_len_q;
					clr_en  = 1'b1;
					clr_idx = rf_idx_q;
				end else if (rf_found_q) begin
					wa_en  = 1'b1;
					wa_idx = rf_idx_q;
					wa_s   = pos_q;
					wa_l   = P'(ps_q) + rf_len_q;
				end else if (bef_found_q && bef_end_ew == pos_ew) begin
					wa_en  = 1'b1;
					wa_idx = bef_idx_q;
					wa_s   = bef_start_q;
					wa_l   = bef_len_q + P'(ps_q);
				end else if (!slot_found_q) begin
					d_stat = STAT_FULL;
				end else begin
					wa_en  = 1'b1;
					wa_idx = slot_idx_q;
					wa_s   = pos_q;
					wa_l   = P'(ps_q);
				end
			end
			default: begin
				d_stat = STAT_OK;
			end
		endcase
		if (d_stat != STAT_OK) begin
			d_res    = '0;
			d_end_en = 1'b0;
			wa_en    = 1'b0;
			wb_en    = 1'b0;
			clr_en   = 1'b0;
		end
	end

	`BFHA_ASSERT(a_pad_kick, pad_go_q |-> state_q == ST_PAD)
	`BFHA_NEVER(a_we_outside_write, ram_we && !(state_q == ST_WRA || state_q == ST_FIN))
	`BFHA_ASSERT(a_two_writes_distinct, (wa_en_q && wb_en_q) |-> wa_idx_q != wb_idx_q)
	`BFHA_ASSERT(a_error_keeps_end, (state_q == ST_DECIDE && d_stat != STAT_OK) |=> $stable(end_q))

endmodule

// ===== src/bfha_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module bfha_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/bfha_pad.sv =====
// rounds a size up to a multiple of the pad unit
// restoring remainder, one bit per cycle; uses bfha_pkg
module bfha_pad (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bfha_pkg::SZ_W-1:0]   sz,
	input  logic [bfha_pkg::PAD_W-1:0]  unit,
	output logic                        done,
	output logic [bfha_pkg::PS_W-1:0]   ps
);
	import bfha_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [4:0]         cnt_q;
	logic [SZ_W-1:0]    sh_q;
	logic [SZ_W-1:0]    sz_q;
	logic [PAD_W-1:0]   rem_q;
	logic [PAD_W-1:0]   p_q;
	logic [PAD_W:0]     trial;

	assign trial = {rem_q, sh_q[SZ_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q   <= (unit == '0) ? PAD_W'(1) : unit;
			sh_q  <= sz;
			sz_q  <= sz;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q <= {sh_q[SZ_W-2:0], 1'b0};
			if (trial >= {1'b0, p_q}) begin
				rem_q <= PAD_W'(trial - {1'b0, p_q});
			end else begin
				rem_q <= trial[PAD_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign ps   = (rem_q != '0) ? ({1'b0, sz_q} - PS_W'(rem_q) + PS_W'(p_q)) : {1'b0, sz_q};

endmodule
